/* sv/fqd_pkg.sv */
// Package for the FIFO queue with delete-by-value block.
// Holds the default sizes, the command codes and the status codes; no dependencies.
`default_nettype none

package fqd_pkg;

  localparam int unsigned DEPTH_DEF       = 16;
  localparam int unsigned VALUE_WIDTH_DEF = 32;

  localparam int unsigned CMD_W = 2;

  // Command code 3 has no meaning and is answered with an error.
  typedef enum logic [CMD_W-1:0] {
    CMD_ENQ = 2'd0,
    CMD_DEQ = 2'd1,
    CMD_DEL = 2'd2
  } cmd_t;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

endpackage

`default_nettype wire

/* sv/fifo_queue_with_delete_unit.sv */
// Top level of the FIFO queue with delete-by-value block.
// Depends on fqd_pkg for sizes, command codes and status codes.
//
// Usage:
// Commands arrive on the slave stream (s_tvalid, s_tready, s_tdata). Each
// transfer carries a command (enqueue, dequeue or delete) and a value. Every
// command produces exactly one result transfer on the master stream
// (m_tvalid, m_tready, m_tdata) with a status bit, the dequeued value (zero
// unless a dequeue succeeded) and the queue length after the command.
// The block works on one command at a time: s_tready is high only while the
// sequencer is idle. Entries live in a single-port-write, registered-read
// memory used as a ring with a head pointer, and two address adders (read
// and write side) and one value comparator are reused on every cycle.
// An enqueue and the immediate errors go straight to the finish step; a dequeue
// reads the head entry first. A delete runs a one-entry-per-cycle memory scan
// that finds the oldest match and, when one is removed, a one-entry-per-cycle
// copy that closes the gap behind it.
// The result sits in an output register; while the receiver stalls, the sequencer can
// still take the next command, but holds in its finish step until that register is free.
// Reset (rst, synchronous) empties the queue and drops any pending result;
// the memory is not cleared, since only written entries are ever read.
`default_nettype none

module fifo_queue_with_delete_unit #(
  parameter int unsigned DEPTH       = fqd_pkg::DEPTH_DEF,
  parameter int unsigned VALUE_WIDTH = fqd_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic s_tvalid,
  output logic      s_tready,
  // Fields from bit 0 up: cmd, item_value, zero fill.
  input  wire logic [((fqd_pkg::CMD_W + VALUE_WIDTH + 7) / 8) * 8 - 1:0] s_tdata,
  output logic      m_tvalid,
  input  wire logic m_tready,
  // Fields from bit 0 up: status, out_value, length, zero fill.
  output logic [((1 + VALUE_WIDTH + $clog2(DEPTH + 1) + 7) / 8) * 8 - 1:0] m_tdata
);

  localparam int unsigned PTR_W  = $clog2(DEPTH);
  localparam int unsigned LEN_W  = $clog2(DEPTH + 1);
  localparam int unsigned CMD_W  = fqd_pkg::CMD_W;
  localparam int unsigned OUT_W  = 1 + VALUE_WIDTH + LEN_W;
  localparam int unsigned OUT_TW = ((OUT_W + 7) / 8) * 8;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DEQ_RD,
    ST_DEQ_DATA,
    ST_SCAN,
    ST_SHIFT,
    ST_FINISH
  } state_t;

  state_t state;

  // Queue bookkeeping.
  logic [PTR_W-1:0] head;
  logic [LEN_W-1:0] count;

  // Sequencer working registers.
  logic [LEN_W-1:0]       idx;
  logic [LEN_W-1:0]       cmp_pos;
  logic                   cmp_valid;
  logic [LEN_W-1:0]       wpos;
  logic                   wr_valid;
  logic [VALUE_WIDTH-1:0] val;
  logic                   res_status;
  logic [VALUE_WIDTH-1:0] res_value;

  // Entry memory.
  logic [VALUE_WIDTH-1:0] mem [DEPTH];
  logic [VALUE_WIDTH-1:0] rd_data;
  logic                   rd_en;
  logic [PTR_W-1:0]       rd_addr;
  logic                   wr_en;
  logic [PTR_W-1:0]       wr_addr;
  logic [VALUE_WIDTH-1:0] wr_data;

  // Input fields.
  logic [CMD_W-1:0]       in_cmd;
  logic [VALUE_WIDTH-1:0] in_value;
  logic                   accept;
  logic                   enq_ok;
  logic                   match;
  logic [PTR_W-1:0]       head_inc;

  // Maps a logical position (0 is the oldest entry) to a memory address.
  function automatic logic [PTR_W-1:0] phys(input logic [PTR_W-1:0] base,
                                            input logic [LEN_W-1:0] off);
    logic [LEN_W:0] sum;
    sum = (LEN_W + 1)'(base) + (LEN_W + 1)'(off);
    if (sum >= (LEN_W + 1)'(DEPTH)) begin
      sum = sum - (LEN_W + 1)'(DEPTH);
    end
    return sum[PTR_W-1:0];
  endfunction

  assign in_cmd   = s_tdata[CMD_W-1:0];
  assign in_value = s_tdata[CMD_W +: VALUE_WIDTH];
  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign enq_ok   = (in_value != '0) && (count < LEN_W'(DEPTH));
  assign match    = cmp_valid && (rd_data == val);
  assign head_inc = (head == PTR_W'(DEPTH - 1)) ? '0 : head + 1'b1;

  // The read port always follows the position counter. The write port takes
  // the incoming value on an accepted enqueue and the copied entry while a
  // delete closes its gap.
  always_comb begin
    rd_addr = phys(head, idx);
    rd_en   = 1'b0;
    unique case (state)
      ST_DEQ_RD:        rd_en = 1'b1;
      ST_SCAN, ST_SHIFT: rd_en = (idx < count);
      default:          rd_en = 1'b0;
    endcase
    if (state == ST_SHIFT) begin
      wr_en   = wr_valid;
      wr_addr = phys(head, wpos);
      wr_data = rd_data;
    end else begin
      wr_en   = accept && (in_cmd == CMD_W'(fqd_pkg::CMD_ENQ)) && enq_ok;
      wr_addr = phys(head, count);
      wr_data = in_value;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      head      <= '0;
      count     <= '0;
      m_tvalid  <= 1'b0;
      cmp_valid <= 1'b0;
      wr_valid  <= 1'b0;
    end else begin
      // The finish step drives the valid flag itself.
      if (m_tvalid && m_tready && state != ST_FINISH) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            val       <= in_value;
            idx       <= '0;
            cmp_valid <= 1'b0;
            res_value <= '0;
            unique case (in_cmd)
              CMD_W'(fqd_pkg::CMD_ENQ): begin
                res_status <= enq_ok ? fqd_pkg::STATUS_OK : fqd_pkg::STATUS_ERR;
                if (enq_ok) begin
                  count <= count + 1'b1;
                end
                state <= ST_FINISH;
              end
              CMD_W'(fqd_pkg::CMD_DEQ): begin
                res_status <= fqd_pkg::STATUS_ERR;
                state      <= (count != '0) ? ST_DEQ_RD : ST_FINISH;
              end
              CMD_W'(fqd_pkg::CMD_DEL): begin
                res_status <= fqd_pkg::STATUS_ERR;
                state      <= (in_value != '0 && count != '0) ? ST_SCAN : ST_FINISH;
              end
              default: begin
                res_status <= fqd_pkg::STATUS_ERR;
                state      <= ST_FINISH;
              end
            endcase
          end
        end
        ST_DEQ_RD: begin
          state <= ST_DEQ_DATA;
        end
        ST_DEQ_DATA: begin
          res_value  <= rd_data;
          res_status <= fqd_pkg::STATUS_OK;
          head       <= head_inc;
          count      <= count - 1'b1;
          state      <= ST_FINISH;
        end
        ST_SCAN: begin
          // One read is issued per cycle; its data is compared in the following cycle.
          priority if (match) begin
            idx      <= cmp_pos + 1'b1;
            wr_valid <= 1'b0;
            state    <= ST_SHIFT;
          end else if (idx < count) begin
            cmp_pos   <= idx;
            cmp_valid <= 1'b1;
            idx       <= idx + 1'b1;
          end else begin
            state <= ST_FINISH;
          end
        end
        ST_SHIFT: begin
          // Each entry behind the match moves one place toward the head.
          if (idx < count) begin
            wpos     <= idx - 1'b1;
            wr_valid <= 1'b1;
            idx      <= idx + 1'b1;
          end else begin
            wr_valid   <= 1'b0;
            count      <= count - 1'b1;
            res_status <= fqd_pkg::STATUS_OK;
            state      <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= OUT_TW'({count, res_value, res_status});
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* sv/fqd_checker.sv */
// Port-level checker for the FIFO queue with delete-by-value block, with its bind.
// Depends on fqd_pkg and on the ports of fifo_queue_with_delete_unit.
`default_nettype none

module fqd_checker #(
  parameter int unsigned DEPTH       = fqd_pkg::DEPTH_DEF,
  parameter int unsigned VALUE_WIDTH = fqd_pkg::VALUE_WIDTH_DEF
) (
  input wire logic clk,
  input wire logic rst,
  input wire logic s_tvalid,
  input wire logic s_tready,
  input wire logic m_tvalid,
  input wire logic m_tready,
  input wire logic [((1 + VALUE_WIDTH + $clog2(DEPTH + 1) + 7) / 8) * 8 - 1:0] m_tdata
);

  localparam int unsigned LEN_W = $clog2(DEPTH + 1);

  logic                   res_status;
  logic [VALUE_WIDTH-1:0] res_value;
  logic [LEN_W-1:0]       res_length;

  assign res_status = m_tdata[0];
  assign res_value  = m_tdata[1 +: VALUE_WIDTH];
  assign res_length = m_tdata[1 + VALUE_WIDTH +: LEN_W];

  // A stalled result keeps its contents.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // The block works on one command at a time.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("command taken while busy");

  // Reported length never exceeds the capacity.
  a_len: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> res_length <= LEN_W'(DEPTH))
    else $error("length beyond capacity");

  // An error result never carries a value.
  a_errval: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (res_status == fqd_pkg::STATUS_ERR) |-> res_value == '0)
    else $error("error result with nonzero value");

  // A value is only returned by a dequeue, which shortens the queue.
  a_deqlen: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (res_value != '0) |-> res_length < LEN_W'(DEPTH))
    else $error("dequeue result with full length");

endmodule

bind fifo_queue_with_delete_unit fqd_checker #(
  .DEPTH       (DEPTH),
  .VALUE_WIDTH (VALUE_WIDTH)
) u_fqd_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire

/* tb/sv/tb_fifo_queue_with_delete_unit.sv */
// Self-checking testbench for fifo_queue_with_delete_unit.
// Drives command transfers, predicts every result from its own queue model and
// checks each result transfer; depends on fqd_pkg and the block under test.
`default_nettype none

module tb_fifo_queue_with_delete_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH = fqd_pkg::DEPTH_DEF;
  localparam int unsigned VW    = fqd_pkg::VALUE_WIDTH_DEF;
  localparam int unsigned CMD_W = fqd_pkg::CMD_W;
  localparam int unsigned LEN_W = $clog2(DEPTH + 1);
  localparam int unsigned SD_W  = ((CMD_W + VW + 7) / 8) * 8;
  localparam int unsigned MD_W  = ((1 + VW + LEN_W + 7) / 8) * 8;

  // Command code 3 is not defined by the block; it must be answered with an error.
  localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;

  // Sizes of the run.
  localparam int RANDOM_ITEMS  = 1000;
  localparam int SEGMENT_ITEMS = 50;
  localparam int HOLD_AT       = 200;   // results seen before the long receiver hold-off
  localparam int HOLD_CYCLES   = 400;
  localparam int IDLE_LIMIT    = 4000;  // cycles without any transfer before giving up
  localparam int TAIL_CYCLES   = 60;    // covers the slowest delete

  // Bias of a random segment: toward filling, toward draining, or neither.
  typedef enum int {BIAS_FILL, BIAS_DRAIN, BIAS_EVEN} seg_bias_t;

  typedef struct {
    logic [CMD_W-1:0] op;
    logic [VW-1:0]    value;
    bit               wait_empty;   // sender pauses until all results are back
  } queue_cmd_t;

  typedef struct {
    logic             status;
    logic [VW-1:0]    out_value;
    logic [LEN_W-1:0] length;
  } queue_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic            s_tvalid = 1'b0;
  logic            s_tready;
  // Fields from bit 0 up: cmd, item_value, zero fill.
  logic [SD_W-1:0] s_tdata = '0;
  logic            m_tvalid;
  logic            m_tready = 1'b0;
  // Fields from bit 0 up: status, out_value, length, zero fill.
  logic [MD_W-1:0] m_tdata;

  fifo_queue_with_delete_unit #(
    .DEPTH      (DEPTH),
    .VALUE_WIDTH(VW)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  // Commands waiting to be offered, and results the queue model says must come.
  queue_cmd_t    cmd_backlog[$];
  queue_result_t pending_results[$];

  // Model of the queue contents, oldest entry at index 0.
  logic [VW-1:0] model_entries[DEPTH];
  int            model_count = 0;

  int cmds_accepted    = 0;
  int results_accepted = 0;
  int cmds_issued      = 0;
  int err_count        = 0;

  // Clock and the single reset pulse at the start of the run.
  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
  end

  // Queue model: applies one accepted command and records the result it must produce.
  // A delete removes the oldest matching entry and slides the younger ones down.
  task automatic apply_queue_command(input logic [CMD_W-1:0] op, input logic [VW-1:0] val);
    queue_result_t r;
    int            hit;
    r.status    = fqd_pkg::STATUS_ERR;
    r.out_value = '0;
    case (op)
      fqd_pkg::CMD_ENQ: begin
        if (val != '0 && model_count < DEPTH) begin
          model_entries[model_count] = val;
          model_count++;
          r.status = fqd_pkg::STATUS_OK;
        end
      end
      fqd_pkg::CMD_DEQ: begin
        if (model_count != 0) begin
          r.out_value = model_entries[0];
          for (int i = 1; i < model_count; i++) model_entries[i-1] = model_entries[i];
          model_count--;
          r.status = fqd_pkg::STATUS_OK;
        end
      end
      fqd_pkg::CMD_DEL: begin
        if (val != '0) begin
          hit = -1;
          for (int i = 0; i < model_count; i++) begin
            if (hit < 0 && model_entries[i] == val) hit = i;
          end
          if (hit >= 0) begin
            for (int i = hit + 1; i < model_count; i++) model_entries[i-1] = model_entries[i];
            model_count--;
            r.status = fqd_pkg::STATUS_OK;
          end
        end
      end
      default: ;
    endcase
    r.length = LEN_W'(model_count);
    pending_results.push_back(r);
  endtask

  task automatic report_mismatch(input string what, input logic [VW-1:0] got,
                                 input logic [VW-1:0] want);
    $display("MISMATCH result %0d: %s got 0x%0h expected 0x%0h",
             results_accepted, what, got, want);
    err_count++;
  endtask

  task automatic add_cmd(input logic [CMD_W-1:0] op, input logic [VW-1:0] val,
                         input bit wait_empty);
    queue_cmd_t c;
    c.op         = op;
    c.value      = val;
    c.wait_empty = wait_empty;
    cmd_backlog.push_back(c);
  endtask

  // One random command. Values mostly come from a small pool so that deletes find
  // matches and duplicates occur; the rest are null, extreme or fully random words.
  function automatic queue_cmd_t random_cmd(input seg_bias_t bias);
    queue_cmd_t c;
    int         pick;
    int         enq_pct;
    int         deq_pct;
    pick = $urandom_range(0, 99);
    case (bias)
      BIAS_FILL:  begin enq_pct = 65; deq_pct = 15; end
      BIAS_DRAIN: begin enq_pct = 20; deq_pct = 45; end
      default:    begin enq_pct = 40; deq_pct = 30; end
    endcase
    if (pick < enq_pct)             c.op = fqd_pkg::CMD_ENQ;
    else if (pick < enq_pct + deq_pct) c.op = fqd_pkg::CMD_DEQ;
    else if (pick < 95)             c.op = fqd_pkg::CMD_DEL;
    else                            c.op = CMD_UNKNOWN;
    pick = $urandom_range(0, 19);
    if (pick == 0)      c.value = '0;
    else if (pick < 12) c.value = VW'($urandom_range(1, 8));
    else if (pick == 12) c.value = '1;
    else if (pick == 13) c.value = {1'b1, {(VW-1){1'b0}}};
    else                c.value = VW'($urandom());
    c.wait_empty = 1'b0;
    return c;
  endfunction

  // Stimulus: directed corner cases first, then random segments with a bias each.
  initial begin
    queue_cmd_t c;
    seg_bias_t  bias;
    // Errors on an empty queue: dequeue, delete, null enqueue, null delete, unknown code.
    add_cmd(fqd_pkg::CMD_DEQ, 32'h0000_0000, 1'b0);
    add_cmd(fqd_pkg::CMD_DEL, 32'h0000_0005, 1'b0);
    add_cmd(fqd_pkg::CMD_ENQ, 32'h0000_0000, 1'b0);
    add_cmd(fqd_pkg::CMD_DEL, 32'h0000_0000, 1'b0);
    add_cmd(CMD_UNKNOWN, 32'hFFFF_FFFF, 1'b0);
    // Extreme values, and a duplicate so that delete must take the oldest copy.
    add_cmd(fqd_pkg::CMD_ENQ, 32'hFFFF_FFFF, 1'b0);
    add_cmd(fqd_pkg::CMD_ENQ, 32'h0000_0001, 1'b0);
    add_cmd(fqd_pkg::CMD_ENQ, 32'h8000_0000, 1'b0);
    add_cmd(fqd_pkg::CMD_ENQ, 32'h0000_0001, 1'b0);
    add_cmd(fqd_pkg::CMD_DEL, 32'h0000_0001, 1'b0);
    add_cmd(fqd_pkg::CMD_DEL, 32'h0000_0007, 1'b0);
    add_cmd(fqd_pkg::CMD_DEQ, 32'h1234_5678, 1'b0);
    // Fill to the limit, then enqueue once more on a full queue.
    for (int v = 2; v < 16; v++) add_cmd(fqd_pkg::CMD_ENQ, VW'(v), 1'b0);
    add_cmd(fqd_pkg::CMD_ENQ, 32'h0000_0010, 1'b0);
    // Delete at the tail, then at the head.
    add_cmd(fqd_pkg::CMD_DEL, 32'h0000_000F, 1'b0);
    add_cmd(fqd_pkg::CMD_DEL, 32'h8000_0000, 1'b0);

    for (int s = 0; s < RANDOM_ITEMS / SEGMENT_ITEMS; s++) begin
      bias = seg_bias_t'($urandom_range(0, 2));
      for (int k = 0; k < SEGMENT_ITEMS; k++) begin
        c = random_cmd(bias);
        // The first segment always starts once every earlier result is back; some later ones too.
        if (k == 0 && (s == 0 || $urandom_range(0, 3) == 0)) c.wait_empty = 1'b1;
        cmd_backlog.push_back(c);
      end
    end

    while (rst) @(posedge clk);
    while (cmd_backlog.size() != 0 || cmds_accepted != cmds_issued) @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    // Any result that shows up now has no command behind it and is flagged by the monitor.
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("fifo_queue_with_delete_unit regression: pass");
    end else begin
      $display("fifo_queue_with_delete_unit regression: fail");
    end
    $finish;
  end

  // Sender. A slot is free once the offered command has been transferred. Commands go
  // out in bursts of random length separated by random gaps; a command marked to wait
  // for an empty block is held back until every expected result has come.
  int burst_left = 1;
  int gap_left   = 0;

  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (s_tvalid && cmds_accepted != cmds_issued) begin
      // Still waiting for the block to take the command on the bus.
    end else if (gap_left > 0) begin
      gap_left--;
      s_tvalid <= 1'b0;
    end else if (cmd_backlog.size() == 0) begin
      s_tvalid <= 1'b0;
    end else if (cmd_backlog[0].wait_empty && pending_results.size() != 0) begin
      s_tvalid <= 1'b0;
    end else begin
      s_tdata  <= {{(SD_W - CMD_W - VW){1'b0}}, cmd_backlog[0].value, cmd_backlog[0].op};
      s_tvalid <= 1'b1;
      void'(cmd_backlog.pop_front());
      cmds_issued++;
      burst_left--;
      if (burst_left <= 0) begin
        burst_left = $urandom_range(1, 30);
        // About a third of the bursts run straight into the next one.
        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      end
    end
  end

  // Receiver. Its stall pattern is redrawn at random from: always ready, coin flip,
  // mostly stalled, or a fixed pattern from the cycle count. Once, after HOLD_AT
  // results, it holds off for HOLD_CYCLES so that the block backs up its input.
  int        rx_cycle  = 0;
  int        rx_mode   = 0;
  int        hold_left = 0;
  bit        hold_done = 1'b0;

  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      rx_cycle++;
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (!hold_done && results_accepted >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        m_tready <= 1'b0;
      end else begin
        if (rx_cycle % 64 == 0) rx_mode = $urandom_range(0, 3);
        case (rx_mode)
          0:       m_tready <= 1'b1;
          1:       m_tready <= 1'($urandom_range(0, 1));
          2:       m_tready <= ($urandom_range(0, 3) == 0);
          default: m_tready <= (rx_cycle % 5 != 0) && (rx_cycle % 7 != 3);
        endcase
      end
    end
  end

  // Monitor. Results are checked against the oldest expectation first; an accepted
  // command then feeds the queue model. A result can never come at the edge that
  // transfers its own command, so the order of the two steps does not matter.
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result, data", VW'(m_tdata), '0);
        end else begin
          if (m_tdata[0] !== pending_results[0].status)
            report_mismatch("status", VW'(m_tdata[0]), VW'(pending_results[0].status));
          if (m_tdata[VW:1] !== pending_results[0].out_value)
            report_mismatch("out_value", m_tdata[VW:1], pending_results[0].out_value);
          if (m_tdata[VW+LEN_W:VW+1] !== pending_results[0].length)
            report_mismatch("length", VW'(m_tdata[VW+LEN_W:VW+1]),
                            VW'(pending_results[0].length));
          void'(pending_results.pop_front());
        end
        results_accepted <= results_accepted + 1;
      end
      if (s_tvalid && s_tready) begin
        apply_queue_command(s_tdata[CMD_W-1:0], s_tdata[CMD_W+VW-1:CMD_W]);
        cmds_accepted <= cmds_accepted + 1;
      end
    end
  end

  // Watchdog: ends the run when no transfer happens on either side for too long.
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout after %0d cycles without a transfer", idle_cycles);
      $display("fifo_queue_with_delete_unit regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

`default_nettype wire
